FILE: src/uice_pkg.sv
package uice_pkg;

    localparam int VALUE_MAX_W     = 32;
    localparam int VALUE_WIDTH_DEF = 32;
    localparam int CODE_W          = 63;
    localparam int LEN_W           = 6;
    localparam int MODE_W          = 2;
    localparam int S_TDATA_W       = 32;
    localparam int M_TDATA_W       = 72;
    localparam int M_PAD_W         = M_TDATA_W - CODE_W - LEN_W;

    typedef enum logic [MODE_W-1:0] {
        MODE_GAMMA = 2'd0,
        MODE_DELTA = 2'd1,
        MODE_OMEGA = 2'd2
    } mode_t;

    typedef struct packed {
        logic [LEN_W-1:0]  length;
        logic [CODE_W-1:0] code;
    } result_t;

    function automatic logic [LEN_W-1:0] bit_len(input logic [VALUE_MAX_W-1:0] v);
        logic [LEN_W-1:0] n;
        n = '0;
        for (int i = 0; i < VALUE_MAX_W; i++) begin
            if (v[i]) begin
                n = LEN_W'(i + 1);
            end
        end
        return n;
    endfunction

endpackage

FILE: src/universal_integer_code_encoder.sv
// Universal integer code encoder for Elias gamma, delta and omega codes.
// Each request on the slave channel carries one unsigned value in s_tdata.
// Only its low VALUE_WIDTH bits are coded. Each request gives exactly one
// result request on the master channel: the codeword right aligned, with
// its first bit at position length minus one, and its length in bits.
// The code is chosen by cfg_wdata, written when cfg_wen is high: gamma,
// delta or omega; the unused selector codes as gamma. Write it only while
// the block is idle.
// The block is a two-stage pipeline: an input register, then the coding
// logic, then a result register. A request is coded from the input register
// into the result register; one request is accepted in every cycle unless
// the receiver stalls. When it stalls, the result register holds its request
// and the input register still takes one more request if it is empty; after
// that s_tready falls until m_tready returns.
// Reset empties both stages and selects the gamma code.
module universal_integer_code_encoder #(
    parameter int VALUE_WIDTH = uice_pkg::VALUE_WIDTH_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_wen,
    input  logic [uice_pkg::MODE_W-1:0]    cfg_wdata,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [uice_pkg::S_TDATA_W-1:0] s_tdata,   // [31:0] value
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [uice_pkg::M_TDATA_W-1:0] m_tdata    // [62:0] code, [68:63] code_length
);
    import uice_pkg::*;

    mode_t                  code_mode_reg, code_mode_next;
    logic                   in_valid_reg, in_valid_next;
    logic [VALUE_WIDTH-1:0] value_reg, value_next;
    logic                   out_valid_reg, out_valid_next;
    result_t                result_reg, result_next;
    result_t                enc_result;
    logic                   out_adv;

    assign out_adv  = !out_valid_reg || m_tready;
    assign s_tready = !in_valid_reg || out_adv;

    uice_enc #(
        .VALUE_WIDTH(VALUE_WIDTH)
    ) u_enc (
        .mode  (code_mode_reg),
        .value (value_reg),
        .result(enc_result)
    );

    always_comb begin
        code_mode_next = code_mode_reg;
        in_valid_next  = in_valid_reg;
        value_next     = value_reg;
        out_valid_next = out_valid_reg;
        result_next    = result_reg;
        if (cfg_wen) begin
            code_mode_next = mode_t'(cfg_wdata);
        end
        if (s_tready) begin
            in_valid_next = s_tvalid;
            if (s_tvalid) begin
                value_next = s_tdata[VALUE_WIDTH-1:0];
            end
        end
        if (out_adv) begin
            out_valid_next = in_valid_reg;
            if (in_valid_reg) begin
                result_next = enc_result;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            code_mode_reg <= MODE_GAMMA;
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            code_mode_reg <= code_mode_next;
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        value_reg  <= value_next;
        result_reg <= result_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{M_PAD_W{1'b0}}, result_reg.length, result_reg.code};

    a_stage_moves: assert property (@(posedge aclk) disable iff (!aresetn)
        in_valid_reg && out_adv |=> m_tvalid)
        else $error("A request in the input stage was lost on its way to the output.");

    a_ready_only_when_full: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> in_valid_reg && out_valid_reg && !m_tready)
        else $error("The input was stalled although a stage was free.");

    a_length_floor: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> result_reg.length >= LEN_W'(2))
        else $error("A codeword shorter than two bits was produced.");

    a_code_fits: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (result_reg.code >> result_reg.length) == '0)
        else $error("Codeword bits were set above the codeword length.");

endmodule

FILE: src/uice_enc.sv
module uice_enc #(
    parameter int VALUE_WIDTH = uice_pkg::VALUE_WIDTH_DEF
) (
    input  uice_pkg::mode_t              mode,
    input  logic [VALUE_WIDTH-1:0]       value,
    output uice_pkg::result_t            result
);
    import uice_pkg::*;

    logic [VALUE_MAX_W-1:0] x;
    logic                   low_value;
    logic [LEN_W-1:0]       n;
    logic [LEN_W-1:0]       dk;
    logic [LEN_W:0]         gamma_len;
    logic [LEN_W:0]         delta_len;
    logic [CODE_W-1:0]      delta_code;
    logic [4:0]             k2;
    logic [2:0]             k3;
    logic [LEN_W-1:0]       b2;
    logic [LEN_W-1:0]       b3;
    logic [LEN_W-1:0]       pos2;
    logic [LEN_W-1:0]       pos3;
    logic [LEN_W-1:0]       pos4;
    logic [CODE_W-1:0]      om_code;
    logic [LEN_W-1:0]       om_len;

    assign x         = VALUE_MAX_W'(value);
    assign low_value = (x[VALUE_MAX_W-1:1] == '0);
    assign n         = bit_len(x);
    assign dk        = bit_len(VALUE_MAX_W'(n));

    assign gamma_len  = {n, 1'b0} - (LEN_W+1)'(1);
    assign delta_len  = (LEN_W+1)'({dk, 1'b0}) - (LEN_W+1)'(1) + (LEN_W+1)'(n);
    assign delta_code = (CODE_W'(n) << n) | CODE_W'(x);

    // Omega groups: the value, then n-1, then at most two shorter length groups.
    assign k2   = 5'(n - LEN_W'(1));
    assign b2   = bit_len(VALUE_MAX_W'(k2));
    assign k3   = 3'(b2 - LEN_W'(1));
    assign b3   = bit_len(VALUE_MAX_W'(k3));
    assign pos2 = n + LEN_W'(1);
    assign pos3 = pos2 + b2;
    assign pos4 = pos3 + b3;

    always_comb begin
        om_code = CODE_W'(x) << 1;
        om_len  = pos2;
        if (k2 > 5'd1) begin
            om_code = om_code | (CODE_W'(k2) << pos2);
            om_len  = pos3;
            if (k3 > 3'd1) begin
                om_code = om_code | (CODE_W'(k3) << pos3);
                om_len  = pos4;
                if (b3 == LEN_W'(3)) begin
                    om_code = om_code | (CODE_W'(2) << pos4);
                    om_len  = pos4 + LEN_W'(2);
                end
            end
        end
    end

    always_comb begin
        unique case (mode)
            MODE_OMEGA: begin
                if (low_value) begin
                    result.code   = CODE_W'(x[0]);
                    result.length = LEN_W'(2);
                end else begin
                    result.code   = om_code;
                    result.length = om_len;
                end
            end
            MODE_DELTA: begin
                if (low_value) begin
                    result.code   = CODE_W'({1'b1, x[0]});
                    result.length = LEN_W'(2);
                end else begin
                    result.code   = delta_code;
                    result.length = delta_len[LEN_W-1:0];
                end
            end
            default: begin
                if (low_value) begin
                    result.code   = CODE_W'({1'b1, x[0]});
                    result.length = LEN_W'(2);
                end else begin
                    result.code   = CODE_W'(x);
                    result.length = gamma_len[LEN_W-1:0];
                end
            end
        endcase
    end

endmodule

FILE: test/universal_integer_code_encoder_checker.sv
module universal_integer_code_encoder_checker (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_wen,
    input  logic [uice_pkg::MODE_W-1:0]    cfg_wdata,
    input  logic                           s_tvalid,
    input  logic                           s_tready,
    input  logic [uice_pkg::S_TDATA_W-1:0] s_tdata,
    input  logic                           m_tvalid,
    input  logic                           m_tready,
    input  logic [uice_pkg::M_TDATA_W-1:0] m_tdata,
    output int                             fail_count,
    output int                             outstanding
);
    import uice_pkg::*;

    typedef struct {
        logic [CODE_W-1:0] code;
        logic [LEN_W-1:0]  length;
    } codeword_t;

    codeword_t         awaited_codes[$];
    codeword_t         oldest;
    logic [MODE_W-1:0] active_code = MODE_GAMMA;
    logic [CODE_W-1:0] seen_code;
    logic [LEN_W-1:0]  seen_length;
    int                errors = 0;
    int                backlog = 0;

    assign fail_count  = errors;
    assign outstanding = backlog;

    function automatic int unsigned significant_bits(input logic [63:0] v);
        int unsigned n;
        n = 0;
        while (v != 64'd0) begin
            n++;
            v = v >> 1;
        end
        return n;
    endfunction

    function automatic codeword_t encode_value(input logic [MODE_W-1:0] sel,
                                               input logic [S_TDATA_W-1:0] v);
        logic [63:0] x;
        logic [63:0] acc;
        logic [63:0] group;
        int unsigned n;
        int unsigned w;
        int unsigned len;
        codeword_t   r;
        x = 64'(v);
        case (sel)
            MODE_OMEGA: begin
                if (x <= 64'd1) begin
                    acc = x;
                    len = 2;
                end else begin
                    acc   = 64'd0;
                    len   = 1;
                    group = x;
                    while (group > 64'd1) begin
                        w     = significant_bits(group);
                        acc   = acc | (group << len);
                        len   = len + w;
                        group = 64'(w - 1);
                    end
                end
            end
            MODE_DELTA: begin
                if (x <= 64'd1) begin
                    acc = 64'd2 | x;
                    len = 2;
                end else begin
                    n   = significant_bits(x);
                    w   = significant_bits(64'(n));
                    acc = (64'(n) << n) | x;
                    len = 2 * w - 1 + n;
                end
            end
            default: begin
                if (x <= 64'd1) begin
                    acc = 64'd2 | x;
                    len = 2;
                end else begin
                    n   = significant_bits(x);
                    acc = x;
                    len = 2 * n - 1;
                end
            end
        endcase
        r.code   = acc[CODE_W-1:0];
        r.length = len[LEN_W-1:0];
        return r;
    endfunction

    always @(posedge aclk) begin
        if (!aresetn) begin
            active_code <= MODE_GAMMA;
            awaited_codes.delete();
            backlog <= 0;
        end else begin
            if (cfg_wen) begin
                active_code <= cfg_wdata;
            end
            if (s_tvalid && s_tready) begin
                awaited_codes.push_back(encode_value(active_code, s_tdata));
            end
            if (m_tvalid && m_tready) begin
                seen_code   = m_tdata[CODE_W-1:0];
                seen_length = m_tdata[CODE_W +: LEN_W];
                if (awaited_codes.size() == 0) begin
                    $error("unexpected result: code %h, code_length %0d",
                           seen_code, seen_length);
                    errors++;
                end else begin
                    oldest = awaited_codes.pop_front();
                    if (seen_code !== oldest.code) begin
                        $error("code: expected %h, got %h", oldest.code, seen_code);
                        errors++;
                    end
                    if (seen_length !== oldest.length) begin
                        $error("code_length: expected %0d, got %0d",
                               oldest.length, seen_length);
                        errors++;
                    end
                end
            end
            backlog <= awaited_codes.size();
        end
    end

endmodule

FILE: test/universal_integer_code_encoder_tb.sv
module universal_integer_code_encoder_tb;
    import uice_pkg::*;

    localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;
    localparam int CYCLE_LIMIT     = 300000;
    localparam int PHASE_COUNT     = 8;
    localparam int ITEMS_PER_PHASE = 125;

    logic                 aclk = 1'b0;
    logic                 aresetn = 1'b0;
    logic                 cfg_wen = 1'b0;
    logic [MODE_W-1:0]    cfg_wdata = '0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata = '0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;

    int         fail_count;
    int         outstanding;
    int         burst_left = 0;
    int         cycle_count = 0;
    logic [6:0] rx_count = '0;
    logic [1:0] rx_style = 2'd0;

    logic [MODE_W-1:0]    directed_modes[4] = '{MODE_GAMMA, MODE_DELTA, MODE_OMEGA,
                                                MODE_UNUSED};
    logic [S_TDATA_W-1:0] directed_values[6] = '{32'd0, 32'd1, 32'd2, 32'd3,
                                                 32'h8000_0000, 32'hFFFF_FFFF};
    logic [MODE_W-1:0]    phase_modes[PHASE_COUNT] = '{MODE_GAMMA, MODE_OMEGA, MODE_DELTA,
                                                       MODE_UNUSED, MODE_OMEGA, MODE_GAMMA,
                                                       MODE_DELTA, MODE_OMEGA};

    universal_integer_code_encoder dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wen   (cfg_wen),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    universal_integer_code_encoder_checker u_checker (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wen     (cfg_wen),
        .cfg_wdata   (cfg_wdata),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .fail_count  (fail_count),
        .outstanding (outstanding)
    );

    always #2 aclk = ~aclk;

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("universal_integer_code_encoder: mismatch");
            $finish;
        end
    end

    // Whenever rx_count wraps to zero, the receiver picks anew between always ready,
    // random stalls and a periodic stall pattern.
    always @(posedge aclk) begin
        if (rx_count == 7'd0) begin
            rx_style <= 2'($urandom_range(0, 2));
        end
        rx_count <= rx_count - 7'd1;
        case (rx_style)
            2'd0: begin
                m_tready <= 1'b1;
            end
            2'd1: begin
                m_tready <= ($urandom_range(0, 3) != 0);
            end
            default: begin
                m_tready <= (rx_count[3:0] < 4'd5);
            end
        endcase
    end

    function automatic logic [S_TDATA_W-1:0] random_value();
        logic [S_TDATA_W-1:0] v;
        case ($urandom_range(0, 9))
            0: begin
                v = S_TDATA_W'($urandom_range(0, 3));
            end
            1, 2: begin
                v = $urandom;
            end
            default: begin
                v = $urandom >> $urandom_range(0, 31);
            end
        endcase
        return v;
    endfunction

    task automatic send_value(input logic [S_TDATA_W-1:0] v, input bit with_gaps);
        if (with_gaps && burst_left == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge aclk);
            burst_left = $urandom_range(1, 16);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= v;
        do @(posedge aclk); while (!s_tready);
        if (burst_left > 0) begin
            burst_left--;
        end
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (outstanding != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic select_code(input logic [MODE_W-1:0] sel);
        drain();
        cfg_wen   <= 1'b1;
        cfg_wdata <= sel;
        @(posedge aclk);
        cfg_wen   <= 1'b0;
    endtask

    initial begin
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // The first directed group runs on the code selected by reset.
        foreach (directed_modes[m]) begin
            if (m != 0) begin
                select_code(directed_modes[m]);
            end
            foreach (directed_values[i]) begin
                send_value(directed_values[i], 1'b0);
            end
        end

        for (int p = 0; p < PHASE_COUNT; p++) begin
            select_code(phase_modes[p]);
            for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
                send_value(random_value(), (p % 3) != 2);
            end
        end

        drain();
        repeat (4) @(posedge aclk);
        if (fail_count == 0 && outstanding == 0) begin
            $display("universal_integer_code_encoder: match");
        end else begin
            $display("universal_integer_code_encoder: mismatch");
        end
        $finish;
    end

endmodule

FILE: filelist.f
src/uice_pkg.sv
src/uice_enc.sv
src/universal_integer_code_encoder.sv
test/universal_integer_code_encoder_checker.sv
test/universal_integer_code_encoder_tb.sv
